>>> src/arlm_pkg.sv
package arlm_pkg;

   localparam int SAMPLE_W    = 32;
   localparam int LEVEL_W     = 16;
   localparam int FMT_W       = 2;
   localparam int MAG_W       = 24;
   localparam int SQ_W        = 2 * MAG_W;
   localparam int SUM_W       = 64;
   localparam int CNT_W       = 16;
   localparam int MAX_SAMPLES = 32768;

   // Divider and square root sizes.
   localparam int DIV_STEPS   = SUM_W;
   localparam int MEAN_W      = 47;
   localparam int SCALED_W    = MEAN_W + 3;
   localparam int RAD_W       = SCALED_W - 14;
   localparam int SQRT_STEPS  = RAD_W / 2;
   localparam int ROOT_W      = SQRT_STEPS;
   localparam int SREM_W      = ROOT_W + 1;
   localparam int STEP_W      = $clog2(DIV_STEPS);

   localparam logic [MAG_W-1:0] Q23_FULL = MAG_W'(24'h80_0000);

   // Sample format codes.
   localparam logic [FMT_W-1:0] FMT_FLOAT32 = 2'd0;
   localparam logic [FMT_W-1:0] FMT_INT16   = 2'd1;
   localparam logic [FMT_W-1:0] FMT_INT32   = 2'd2;
   localparam logic [FMT_W-1:0] FMT_NONE    = 2'd3;

   typedef struct packed {
      logic accept;
      logic mul;
      logic div_load;
      logic div_step;
      logic scale;
      logic sqrt_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic zero;
      logic out_free;
   } status_type;

endpackage

>>> src/arlm_ifs.sv
interface arlm_req_if;
   logic                          valid;
   logic                          ready;
   logic [arlm_pkg::SAMPLE_W-1:0] sample;
   logic                          silent;
   logic                          last;

   modport source (output valid, output sample, output silent, output last, input ready);
   modport sink   (input valid, input sample, input silent, input last, output ready);
endinterface

interface arlm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [arlm_pkg::LEVEL_W-1:0] level;

   modport source (output valid, output level, input ready);
   modport sink   (input valid, input level, output ready);
endinterface

interface arlm_csr_if;
   logic                       valid;
   logic                       ready;
   logic [arlm_pkg::FMT_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> src/arlm_ctrl.sv
module arlm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  arlm_pkg::status_type status,
   output arlm_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_FLUSH = 3'd2;
   localparam logic [2:0] ST_LOAD  = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_SCALE = 3'd5;
   localparam logic [2:0] ST_SQRT  = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   localparam logic [arlm_pkg::STEP_W-1:0] DIV_LAST  =
      arlm_pkg::STEP_W'(arlm_pkg::DIV_STEPS - 1);
   localparam logic [arlm_pkg::STEP_W-1:0] SQRT_LAST =
      arlm_pkg::STEP_W'(arlm_pkg::SQRT_STEPS - 1);

   logic [2:0]                  state_ff, state_in;
   logic [arlm_pkg::STEP_W-1:0] step_ff, step_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = status.last ? ST_FLUSH : ST_IDLE;
         end
         ST_FLUSH: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            step_in      = '0;
            state_in     = status.zero ? ST_OUT : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            step_in   = '0;
            state_in  = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == SQRT_LAST) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

>>> src/arlm_datapath.sv
module arlm_datapath (
   input  logic                 clock,
   input  logic                 reset,
   arlm_req_if.sink             req_if,
   arlm_rsp_if.source           rsp_if,
   arlm_csr_if.sink             csr_if,
   input  arlm_pkg::cmd_type    cmd,
   output arlm_pkg::status_type status
);

   logic [arlm_pkg::FMT_W-1:0]    fmt_ff;
   logic [arlm_pkg::MAG_W-1:0]    mag_ff, mag_in;
   logic [arlm_pkg::SQ_W-1:0]     sq_ff;
   logic                          sq_vld_ff;
   logic [arlm_pkg::SUM_W-1:0]    sum_ff;
   logic [arlm_pkg::CNT_W-1:0]    count_ff, count_in;
   logic                          silent_ff;
   logic                          last_ff;
   logic                          zero_ff;
   logic [arlm_pkg::SUM_W-1:0]    quo_ff;
   logic [arlm_pkg::CNT_W-1:0]    rem_ff;
   logic [arlm_pkg::RAD_W-1:0]    rad_ff;
   logic [arlm_pkg::ROOT_W-1:0]   root_ff;
   logic [arlm_pkg::SREM_W-1:0]   srem_ff;
   logic                          rsp_valid_ff;
   logic [arlm_pkg::LEVEL_W-1:0]  level_ff;

   logic [7:0]                    f_ex;
   logic [7:0]                    f_sh;
   logic [16:0]                   i16_mag;
   logic [32:0]                   i32_neg;
   logic [32:0]                   i32_rnd;
   logic                          include_sample;
   logic [arlm_pkg::CNT_W:0]      div_trial;
   logic [arlm_pkg::CNT_W:0]      div_diff;
   logic                          div_bit;
   logic [arlm_pkg::SCALED_W-1:0] scaled;
   logic [arlm_pkg::SREM_W+1:0]   sq_part;
   logic [arlm_pkg::SREM_W+1:0]   sq_trial;
   logic                          sq_bit;
   logic [arlm_pkg::LEVEL_W-1:0]  level_sat;

   assign csr_if.ready = 1'b1;

   // Sample word to magnitude in Q1.23.
   always_comb begin
      f_ex    = req_if.sample[30:23];
      f_sh    = 8'd127 - f_ex;
      i16_mag = req_if.sample[15] ? (17'h1_0000 - {1'b0, req_if.sample[15:0]})
                                  : {1'b0, req_if.sample[15:0]};
      i32_neg = 33'h1_0000_0000 - {1'b0, req_if.sample};
      i32_rnd = i32_neg + 33'd255;
      case (fmt_ff)
         arlm_pkg::FMT_FLOAT32: begin
            if (f_ex == 8'hFF) begin
               mag_in = (req_if.sample[22:0] != '0) ? '0 : arlm_pkg::Q23_FULL;
            end else if (f_ex >= 8'd127) begin
               mag_in = arlm_pkg::Q23_FULL;
            end else if (f_ex == 8'd0 || f_sh > 8'd24) begin
               mag_in = '0;
            end else begin
               mag_in = {1'b1, req_if.sample[22:0]} >> f_sh[4:0];
            end
         end
         arlm_pkg::FMT_INT16: begin
            mag_in = {i16_mag[15:0], 8'h00};
         end
         arlm_pkg::FMT_INT32: begin
            mag_in = req_if.sample[31] ? i32_rnd[31:8] : req_if.sample[31:8];
         end
         default: begin
            mag_in = '0;
         end
      endcase
   end

   assign include_sample = (count_ff < arlm_pkg::CNT_W'(arlm_pkg::MAX_SAMPLES));
   assign count_in       = include_sample ? count_ff + 1'b1 : count_ff;

   // Restoring division, one quotient bit per step.
   assign div_trial = {rem_ff, quo_ff[arlm_pkg::SUM_W-1]};
   assign div_diff  = div_trial - {1'b0, count_ff};
   assign div_bit   = (div_trial >= {1'b0, count_ff});

   // mean * 9 as a shift and add.
   assign scaled = {quo_ff[arlm_pkg::MEAN_W-1:0], 3'b000} +
                   arlm_pkg::SCALED_W'(quo_ff[arlm_pkg::MEAN_W-1:0]);

   // Digit recurrence square root, two radicand bits per step.
   assign sq_part  = {srem_ff, rad_ff[arlm_pkg::RAD_W-1 -: 2]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign sq_bit   = (sq_part >= sq_trial);

   assign level_sat = (root_ff > arlm_pkg::ROOT_W'(16'hFFFF)) ? 16'hFFFF
                                                              : root_ff[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff       <= arlm_pkg::FMT_INT16;
         sq_vld_ff    <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
         silent_ff    <= 1'b0;
         last_ff      <= 1'b0;
         zero_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_if.valid) begin
            fmt_ff <= csr_if.data;
         end
         sq_vld_ff <= cmd.mul;
         if (cmd.out_load) begin
            sum_ff    <= '0;
            count_ff  <= '0;
            silent_ff <= 1'b0;
         end else begin
            if (sq_vld_ff) begin
               sum_ff <= sum_ff + arlm_pkg::SUM_W'(sq_ff);
            end
            if (cmd.accept) begin
               count_ff  <= count_in;
               silent_ff <= silent_ff | req_if.silent;
               last_ff   <= req_if.last;
               zero_ff   <= silent_ff | req_if.silent | (fmt_ff == arlm_pkg::FMT_NONE) |
                            (count_in == '0);
            end
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mag_ff <= include_sample ? mag_in : '0;
      end
      if (cmd.mul) begin
         sq_ff <= mag_ff * mag_ff;
      end
      if (cmd.div_load) begin
         quo_ff <= sum_ff;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[arlm_pkg::SUM_W-2:0], div_bit};
         rem_ff <= div_bit ? div_diff[arlm_pkg::CNT_W-1:0] : div_trial[arlm_pkg::CNT_W-1:0];
      end
      if (cmd.scale) begin
         rad_ff  <= scaled[arlm_pkg::SCALED_W-1:14];
         root_ff <= '0;
         srem_ff <= '0;
      end else if (cmd.sqrt_step) begin
         rad_ff  <= {rad_ff[arlm_pkg::RAD_W-3:0], 2'b00};
         root_ff <= {root_ff[arlm_pkg::ROOT_W-2:0], sq_bit};
         srem_ff <= sq_bit ? arlm_pkg::SREM_W'(sq_part - sq_trial)
                           : arlm_pkg::SREM_W'(sq_part);
      end
      if (cmd.out_load) begin
         level_ff <= zero_ff ? '0 : level_sat;
      end
   end

   assign status.last     = last_ff;
   assign status.zero     = zero_ff;
   assign status.out_free = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.level = level_ff;

endmodule

>>> src/audio_rms_level_meter_unit.sv
// A sample that does not end a packet is converted, then squared, before the next is accepted.
// A beat marked last then runs the divider and square root to its result beat: 64 divider steps
// for the mean and 18 square root steps; a zero level (silent, unsupported format) skips both.
// Reset is synchronous and active high: it clears the sum, count, silent mark and output valid,
// and sets the sample format to signed 16-bit.
module audio_rms_level_meter_unit (
   input  logic       clock,
   input  logic       reset,
   arlm_req_if.sink   req_if,
   arlm_rsp_if.source rsp_if,
   arlm_csr_if.sink   csr_if
);

   // The controller sequences one sample at a time. A sample beat is converted to a Q1.23
   // magnitude on acceptance, squared in the next cycle, and the square is accumulated in the
   // cycle after that, which overlaps the acceptance of the next sample.
   arlm_pkg::cmd_type    cmd;
   arlm_pkg::status_type status;
   logic                 ctrl_ready;

   // The input is ready only while the controller waits for a sample.
   assign req_if.ready = ctrl_ready;

   arlm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (ctrl_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the format register, the accumulator, the divider and square
   // root registers, and an output register so that a finished level can wait for the sink
   // while the next packet is already accepted.
   arlm_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if),
      .cmd    (cmd),
      .status (status)
   );

endmodule
